// File: design/dsdw_pkg.sv
// Package for the decimal segment display writer.
// Holds the sequencer state type, result kind codes and the segment and address tables.
// No dependencies.
package dsdw_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_CONVERT,
        ST_CLEAR,
        ST_WR_FIRST,
        ST_WR_SECOND
    } state_t;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    localparam int          VALUE_W  = 25;
    localparam int          POS_IDX_W = 3;
    localparam logic [3:0]  DP_BIT   = 4'b1000;

    function automatic logic [3:0] first_seg(input logic [3:0] d);
        logic [3:0] s;
        case (d)
            4'd0:    s = 4'hF;
            4'd1:    s = 4'h0;
            4'd2:    s = 4'hD;
            4'd3:    s = 4'h9;
            4'd4:    s = 4'h2;
            4'd5:    s = 4'hB;
            4'd6:    s = 4'hF;
            4'd7:    s = 4'h1;
            4'd8:    s = 4'hF;
            4'd9:    s = 4'hB;
            default: s = 4'h0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] second_seg(input logic [3:0] d);
        logic [3:0] s;
        case (d)
            4'd0:    s = 4'h5;
            4'd1:    s = 4'h5;
            4'd2:    s = 4'h3;
            4'd3:    s = 4'h7;
            4'd4:    s = 4'h7;
            4'd5:    s = 4'h6;
            4'd6:    s = 4'h6;
            4'd7:    s = 4'h5;
            4'd8:    s = 4'h7;
            4'd9:    s = 4'h7;
            default: s = 4'h0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] first_addr(input logic [POS_IDX_W-1:0] p);
        logic [4:0] a;
        case (p)
            3'd0:    a = 5'd19;
            3'd1:    a = 5'd21;
            3'd2:    a = 5'd9;
            3'd3:    a = 5'd11;
            3'd4:    a = 5'd13;
            3'd5:    a = 5'd15;
            3'd6:    a = 5'd17;
            default: a = 5'd0;
        endcase
        return a;
    endfunction

    function automatic logic [4:0] second_addr(input logic [POS_IDX_W-1:0] p);
        logic [4:0] a;
        case (p)
            3'd0:    a = 5'd18;
            3'd1:    a = 5'd20;
            3'd2:    a = 5'd22;
            3'd3:    a = 5'd10;
            3'd4:    a = 5'd12;
            3'd5:    a = 5'd14;
            3'd6:    a = 5'd16;
            default: a = 5'd0;
        endcase
        return a;
    endfunction

endpackage

// File: design/dsdw_dabble.sv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Used by the decimal segment display writer; no package dependencies.
module dsdw_dabble #(
    parameter int NUM_DIGITS = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [$clog2(10**NUM_DIGITS)-1:0]   bin_in,
    output logic                                done,
    output logic [4*NUM_DIGITS-1:0]             bcd
);

    localparam int BIN_W = $clog2(10**NUM_DIGITS);
    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int CNT_W = $clog2(BIN_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] adj;

    // Every digit that has reached five is bumped by three before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (load)
        begin
            cnt_next = CNT_W'(BIN_W);
            bin_next = bin_in;
            bcd_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = (cnt_reg == '0);
    assign bcd  = bcd_reg;

endmodule

// File: design/decimal_segment_display_writer_top.sv
// Top level of the decimal segment display writer: sequencer and result formatting.
// Depends on dsdw_pkg and dsdw_dabble.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+--------------------------
//  request   | req_type, value                               | start high, busy low
//  result    | kind, seg_address, seg_nibble, last           | strobe, one cycle, no stall
//
// A request out of range gives its single word the cycle after acceptance.
// A valid request is accepted, then converted by shift and add-3 in the converter (BIN_W
// bits, 24 at seven digits), and the sequencer waits until it sees the converter finish.
// It then gives one clear word and two words per shown digit, one word a cycle.
// busy is high from the cycle after acceptance through the last word; reset is
// asynchronous and returns the sequencer to idle. The receiver cannot stall results.
module decimal_segment_display_writer_top #(
    parameter int NUM_DIGITS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic signed [dsdw_pkg::VALUE_W-1:0] value,
    output logic                          strobe,
    output logic [1:0]                    kind,
    output logic [4:0]                    seg_address,
    output logic [3:0]                    seg_nibble,
    output logic                          last
);

    import dsdw_pkg::*;

    localparam int                 BIN_W = $clog2(10**NUM_DIGITS);
    localparam int                 MAG_W = VALUE_W - 1;
    localparam logic [MAG_W-1:0]   LIMIT = MAG_W'(10**NUM_DIGITS);
    localparam int                 POS_W = $clog2(NUM_DIGITS);
    localparam int                 LEN_W = $clog2(NUM_DIGITS + 1);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               mode_reg, mode_next;

    logic                     accept;
    logic                     out_of_range;
    logic                     cvt_load;
    logic                     cvt_done;
    logic [4*NUM_DIGITS-1:0]  cvt_bcd;
    logic [LEN_W-1:0]         shown_len;
    logic [3:0]               digit;
    logic                     final_pos;

    assign accept       = start && (state_reg == ST_IDLE);
    assign out_of_range = value[VALUE_W-1] || (value[MAG_W-1:0] >= LIMIT);
    assign cvt_load     = accept && !out_of_range;

    dsdw_dabble #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (cvt_load),
        .bin_in (value[BIN_W-1:0]),
        .done   (cvt_done),
        .bcd    (cvt_bcd)
    );

    // Shown length: the highest nonzero digit, but never below the mode's minimum.
    always_comb
    begin
        shown_len = mode_reg ? LEN_W'(3) : LEN_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if ((cvt_bcd[i*4 +: 4] != 4'd0) && (LEN_W'(i + 1) > shown_len))
                shown_len = LEN_W'(i + 1);
        end
    end

    assign digit     = cvt_bcd[pos_reg*4 +: 4];
    assign final_pos = (LEN_W'(pos_reg) == len_reg - 1'b1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        mode_next  = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req_type;
                    pos_next  = '0;
                    if (out_of_range)
                        state_next = ST_ERROR;
                    else
                        state_next = ST_CONVERT;
                end
            end
            ST_ERROR:
                state_next = ST_IDLE;
            ST_CONVERT:
            begin
                if (cvt_done)
                begin
                    len_next   = shown_len;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
                state_next = ST_WR_FIRST;
            ST_WR_FIRST:
                state_next = ST_WR_SECOND;
            ST_WR_SECOND:
            begin
                if (final_pos)
                    state_next = ST_IDLE;
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_WR_FIRST;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy        = 1'b1;
        strobe      = 1'b0;
        kind        = KIND_CLEAR;
        seg_address = 5'd0;
        seg_nibble  = 4'd0;
        last        = 1'b0;
        case (state_reg)
            ST_IDLE:
                busy = 1'b0;
            ST_ERROR:
            begin
                strobe = 1'b1;
                kind   = KIND_RANGE;
                last   = 1'b1;
            end
            ST_CONVERT:
                strobe = 1'b0;
            ST_CLEAR:
            begin
                strobe = 1'b1;
                kind   = KIND_CLEAR;
            end
            ST_WR_FIRST:
            begin
                strobe      = 1'b1;
                kind        = KIND_WRITE;
                seg_address = first_addr(POS_IDX_W'(pos_reg));
                seg_nibble  = first_seg(digit);
            end
            ST_WR_SECOND:
            begin
                strobe      = 1'b1;
                kind        = KIND_WRITE;
                seg_address = second_addr(POS_IDX_W'(pos_reg));
                seg_nibble  = second_seg(digit);
                // The units digit of an amount (position two) carries the decimal point.
                if (mode_reg && (POS_IDX_W'(pos_reg) == POS_IDX_W'(2)))
                    seg_nibble = second_seg(digit) | DP_BIT;
                last        = final_pos;
            end
            default:
                busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            mode_reg  <= mode_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy did not rise");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("block still busy after the last word");

    a_clear_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == KIND_CLEAR)) |=> (strobe && (kind == KIND_WRITE)))
        else $error("clear word not followed by a nibble write");

    a_write_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == KIND_WRITE) && !last) |=> strobe)
        else $error("gap in the nibble write sequence");

endmodule
